FILE: hw/rtl/assert_macros.svh
// assertion helpers shared by the monitor rtl
// depends on clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define LSPM_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define LSPM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the cycle after
`define LSPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/lspm_pkg.sv
// shared types and constants of the latency statistics monitor
// no dependencies; used by every rtl module of the block
package lspm_pkg;

  localparam int FRAC_W    = 14;
  localparam int CFG_IDX_W = 2;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;
  localparam int DVD_W     = 72;
  localparam int DVS_W     = 48;

  // function codes
  localparam logic [1:0] FUNC_RECORD   = 2'd0;
  localparam logic [1:0] FUNC_SNAPSHOT = 2'd1;
  localparam logic [1:0] FUNC_QUERY    = 2'd2;
  localparam logic [1:0] FUNC_CLEAR    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_FRACTION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_FRACTION = 2'd1;

  localparam logic [FRAC_W-1:0] LOW_FRACTION_RST  = 14'd9500;
  localparam logic [FRAC_W-1:0] HIGH_FRACTION_RST = 14'd9900;
  localparam logic [FRAC_W-1:0] FRAC_ONE          = 14'd10000;

  localparam logic [9:0] STATUS_OK_LO = 10'd200;
  localparam logic [9:0] STATUS_OK_HI = 10'd400;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  resp_status;
    logic [31:0] latency_us;
    logic [31:0] sent_bytes;
    logic [31:0] received_bytes;
    logic [13:0] query_fraction;
  } lspm_in_t;

  typedef struct packed {
    logic [47:0] request_count;
    logic [47:0] success_count;
    logic [47:0] failure_count;
    logic [47:0] sent_total;
    logic [47:0] received_total;
    logic [39:0] mean_latency;
    logic [31:0] latency_min;
    logic [31:0] latency_max;
    logic [31:0] low_percentile;
    logic [31:0] high_percentile;
    logic [31:0] query_result;
  } lspm_out_t;

  // classified command between front and back
  typedef struct packed {
    logic [1:0]        func;
    logic              success;
    logic [31:0]       latency;
    logic [31:0]       sent;
    logic [31:0]       received;
    logic [FRAC_W-1:0] fraction;
  } lspm_cmd_t;

  typedef struct packed {
    logic [FRAC_W-1:0] low_fraction;
    logic [FRAC_W-1:0] high_fraction;
  } lspm_cfg_t;

endpackage

FILE: hw/rtl/lspm_front.sv
// front end: configuration registers, input classification, command queue
// depends on lspm_pkg and assert_macros.svh
`include "assert_macros.svh"
module lspm_front
  import lspm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  lspm_in_t             in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAC_W-1:0]    cfg_data,
  output lspm_cfg_t            cfg,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output lspm_cmd_t            cmd
);

  logic [FRAC_W-1:0]  low_frac_r;
  logic [FRAC_W-1:0]  high_frac_r;
  lspm_cmd_t          q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               push_fire;
  logic               pop_fire;
  lspm_cmd_t          classified;

  // configuration registers, writes always taken
  assign cfg_ready = 1'b1;
  assign cfg.low_fraction  = low_frac_r;
  assign cfg.high_fraction = high_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_frac_r  <= LOW_FRACTION_RST;
      high_frac_r <= HIGH_FRACTION_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_LOW_FRACTION) low_frac_r <= cfg_data;
      if (cfg_index == REG_HIGH_FRACTION) high_frac_r <= cfg_data;
    end
  end

  // classify status into success or failure
  always_comb begin
    classified.func     = in_data.func;
    classified.success  = (in_data.resp_status >= STATUS_OK_LO) &&
                          (in_data.resp_status < STATUS_OK_HI);
    classified.latency  = in_data.latency_us;
    classified.sent     = in_data.sent_bytes;
    classified.received = in_data.received_bytes;
    classified.fraction = in_data.query_fraction;
  end

  // command queue
  assign in_full   = (count_r == Q_CNT_W'(Q_DEPTH));
  assign push_fire = in_push && !in_full;
  assign cmd_valid = (count_r != '0);
  assign pop_fire  = cmd_valid && cmd_ready;
  assign cmd       = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_fire) q_mem_r[wr_ptr_r] <= classified;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_fire) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push_fire && !pop_fire) count_r <= count_r + 1'b1;
      else if (!push_fire && pop_fire) count_r <= count_r - 1'b1;
    end
  end

  `LSPM_ASSERT(a_q_bound, count_r <= Q_CNT_W'(Q_DEPTH), "command queue over depth")
  `LSPM_ASSERT_NEXT(a_q_grow, push_fire && !pop_fire, count_r == $past(count_r) + 1'b1, "queue count lost a transfer")

endmodule

FILE: hw/rtl/lspm_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on lspm_pkg
module lspm_div
  import lspm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  logic             busy_r;
  logic [6:0]       step_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  // shift in one dividend bit, subtract when it fits
  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign diff     = rem_sh - {1'b0, dvs_r};
  assign ge       = (rem_sh >= {1'b0, dvs_r});
  assign done     = !busy_r;
  assign quotient = dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == 7'(DVD_W - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
    end
  end

endmodule

FILE: hw/rtl/lspm_back.sv
// back end: statistics, sample ring, order statistic selection, result register
// depends on lspm_pkg, lspm_div and assert_macros.svh
`include "assert_macros.svh"
module lspm_back
  import lspm_pkg::*;
#(
  parameter int RING_DEPTH = 1024,
  parameter int WINDOW     = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  lspm_cmd_t cmd,
  input  lspm_cfg_t cfg,
  output logic      out_empty,
  input  logic      out_pop,
  output lspm_out_t out_data
);

  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int PW      = CNT_W + FRAC_W;
  localparam int WIN_EFF = (WINDOW < RING_DEPTH) ? WINDOW : RING_DEPTH;
  localparam logic [CNT_W-1:0] RING_N    = CNT_W'(RING_DEPTH);
  localparam logic [CNT_W-1:0] WIN_N     = CNT_W'(WIN_EFF);
  localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(RING_DEPTH - 1);

  // 10000 = 16 * 625: drop four bits, then multiply by a rounded-up 2^RS / 625
  localparam int QX_W = PW - 4;
  localparam int RS   = QX_W + 10;
  localparam int RM_W = RS - 8;
  localparam int QW   = QX_W - 8;
  localparam logic [RM_W-1:0] RECIP = RM_W'(((64'd1 << RS) + 64'd624) / 64'd625);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_INDEX  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]        state_r;
  logic [47:0]       req_r, ok_r, fail_r, sent_r, recv_r;
  logic [63:0]       lat_sum_r;
  logic [31:0]       min_r, max_r;
  logic [31:0]       ring [RING_DEPTH];
  logic [PTR_W-1:0]  wp_r;
  logic [CNT_W-1:0]  fill_r;

  logic              is_snap_r;
  logic              res_zero_r;
  logic [CNT_W-1:0]  n_r;
  logic [FRAC_W-1:0] frac_a_r, frac_b_r;
  logic [PW-1:0]     prod_a_r, prod_b_r;
  logic [CNT_W-1:0]  k_a_r, k_b_r;
  logic [CNT_W-1:0]  i_r;
  logic [PTR_W-1:0]  addr_r;
  logic [31:0]       rd_data_r;
  logic              rd_vld_r;
  logic [31:0]       bit_r;
  logic [31:0]       prefix_a_r, prefix_b_r;
  logic [CNT_W-1:0]  cnt_a_r, cnt_b_r;
  logic              out_valid_r;
  lspm_out_t         out_r;
  lspm_out_t         out_nxt;

  logic              cmd_fire;
  logic              rec_fire;
  logic              div_start;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;
  logic [48:0]       req_sum, ok_sum, fail_sum, sent_sum, recv_sum;
  logic [64:0]       lat_sum;
  logic [47:0]       req_nxt, ok_nxt, fail_nxt, sent_nxt, recv_nxt;
  logic [63:0]       lat_sum_nxt;
  logic [CNT_W-1:0]  n_cur;
  logic [PTR_W-1:0]  start_addr;
  logic [PTR_W-1:0]  addr_dec;
  logic [QX_W+RM_W-1:0] mul_a, mul_b;
  logic [QW-1:0]     quo_a, quo_b;
  logic [CNT_W-1:0]  n_m1;
  logic [CNT_W-1:0]  q_a_cl, q_b_cl;
  logic              issue;
  logic [31:0]       cand_a, cand_b;
  logic              out_load;
  logic [39:0]       mean_val;

  assign cmd_ready = (state_r == ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign rec_fire  = cmd_fire && (cmd.func == FUNC_RECORD);
  assign div_start = cmd_fire && (cmd.func == FUNC_SNAPSHOT);

  // saturating counters and sums
  assign req_sum  = {1'b0, req_r} + 49'd1;
  assign ok_sum   = {1'b0, ok_r} + 49'd1;
  assign fail_sum = {1'b0, fail_r} + 49'd1;
  assign sent_sum = {1'b0, sent_r} + {17'd0, cmd.sent};
  assign recv_sum = {1'b0, recv_r} + {17'd0, cmd.received};
  assign lat_sum  = {1'b0, lat_sum_r} + {33'd0, cmd.latency};
  assign req_nxt  = req_sum[48] ? '1 : req_sum[47:0];
  assign ok_nxt   = ok_sum[48] ? '1 : ok_sum[47:0];
  assign fail_nxt = fail_sum[48] ? '1 : fail_sum[47:0];
  assign sent_nxt = sent_sum[48] ? '1 : sent_sum[47:0];
  assign recv_nxt = recv_sum[48] ? '1 : recv_sum[47:0];
  assign lat_sum_nxt = lat_sum[64] ? '1 : lat_sum[63:0];

  // window size and ring walk from the newest sample backward
  assign n_cur      = (fill_r > WIN_N) ? WIN_N : fill_r;
  assign start_addr = (wp_r == '0) ? LAST_ADDR : wp_r - 1'b1;
  assign addr_dec   = (addr_r == '0) ? LAST_ADDR : addr_r - 1'b1;

  // rank index: product divided by the fraction scale, exact for every product
  assign mul_a  = prod_a_r[PW-1:4] * RECIP;
  assign mul_b  = prod_b_r[PW-1:4] * RECIP;
  assign quo_a  = mul_a[QX_W+RM_W-1:RS];
  assign quo_b  = mul_b[QX_W+RM_W-1:RS];
  assign n_m1   = n_r - 1'b1;
  assign q_a_cl = (quo_a > QW'(n_m1)) ? n_m1 : quo_a[CNT_W-1:0];
  assign q_b_cl = (quo_b > QW'(n_m1)) ? n_m1 : quo_b[CNT_W-1:0];

  // candidate with the tested bit clear and lower bits set
  assign issue  = (state_r == ST_SCAN) && (i_r != n_r);
  assign cand_a = prefix_a_r | (bit_r - 32'd1);
  assign cand_b = prefix_b_r | (bit_r - 32'd1);

  assign out_load = (state_r == ST_FINISH) && (!is_snap_r || div_done) && !out_valid_r;
  assign mean_val = (req_r == '0) ? '0 :
                    (div_q[DVD_W-1:40] != '0) ? '1 : div_q[39:0];

  lspm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({lat_sum_r, 8'h00}),
    .divisor  (req_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // sample ring, one write and one registered read port
  always_ff @(posedge clk) begin
    if (rec_fire) ring[wp_r] <= cmd.latency;
    if (issue) rd_data_r <= ring[addr_r];
  end

  // statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= '0; ok_r <= '0; fail_r <= '0; sent_r <= '0; recv_r <= '0;
      lat_sum_r <= '0; min_r <= '1; max_r <= '0; wp_r <= '0; fill_r <= '0;
    end else if (cmd_fire && cmd.func == FUNC_CLEAR) begin
      req_r <= '0; ok_r <= '0; fail_r <= '0; sent_r <= '0; recv_r <= '0;
      lat_sum_r <= '0; min_r <= '1; max_r <= '0; wp_r <= '0; fill_r <= '0;
    end else if (rec_fire) begin
      req_r     <= req_nxt;
      if (cmd.success) ok_r <= ok_nxt;
      else fail_r <= fail_nxt;
      sent_r    <= sent_nxt;
      recv_r    <= recv_nxt;
      lat_sum_r <= lat_sum_nxt;
      if (cmd.latency < min_r) min_r <= cmd.latency;
      if (cmd.latency > max_r) max_r <= cmd.latency;
      wp_r      <= (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
      if (fill_r != RING_N) fill_r <= fill_r + 1'b1;
    end
  end

  // selection sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_fire && (cmd.func == FUNC_SNAPSHOT || cmd.func == FUNC_QUERY)) begin
            is_snap_r  <= (cmd.func == FUNC_SNAPSHOT);
            frac_a_r   <= (cmd.func == FUNC_SNAPSHOT) ? cfg.low_fraction : cmd.fraction;
            frac_b_r   <= cfg.high_fraction;
            n_r        <= n_cur;
            res_zero_r <= (n_cur == '0) ||
                          ((cmd.func == FUNC_QUERY) && (cmd.fraction > FRAC_ONE));
            state_r    <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_a_r <= PW'(n_r * frac_a_r);
          prod_b_r <= PW'(n_r * frac_b_r);
          state_r  <= ST_INDEX;
        end
        ST_INDEX: begin
          k_a_r      <= q_a_cl;
          k_b_r      <= (q_b_cl < q_a_cl) ? q_a_cl : q_b_cl;
          i_r        <= '0;
          addr_r     <= start_addr;
          bit_r      <= 32'h8000_0000;
          prefix_a_r <= '0;
          prefix_b_r <= '0;
          cnt_a_r    <= '0;
          cnt_b_r    <= '0;
          state_r    <= res_zero_r ? ST_FINISH : ST_SCAN;
        end
        ST_SCAN: begin
          if (issue) begin
            i_r    <= i_r + 1'b1;
            addr_r <= addr_dec;
          end
          // count samples not above each candidate
          if (rd_vld_r) begin
            if (rd_data_r <= cand_a) cnt_a_r <= cnt_a_r + 1'b1;
            if (rd_data_r <= cand_b) cnt_b_r <= cnt_b_r + 1'b1;
          end
          // end of a pass settles one bit of each answer
          if (!issue && !rd_vld_r) begin
            if (cnt_a_r <= k_a_r) prefix_a_r <= prefix_a_r | bit_r;
            if (cnt_b_r <= k_b_r) prefix_b_r <= prefix_b_r | bit_r;
            cnt_a_r <= '0;
            cnt_b_r <= '0;
            i_r     <= '0;
            addr_r  <= start_addr;
            bit_r   <= bit_r >> 1;
            if (bit_r[0]) state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result word of the finished command
  always_comb begin
    out_nxt = '0;
    if (is_snap_r) begin
      out_nxt.request_count   = req_r;
      out_nxt.success_count   = ok_r;
      out_nxt.failure_count   = fail_r;
      out_nxt.sent_total      = sent_r;
      out_nxt.received_total  = recv_r;
      out_nxt.mean_latency    = mean_val;
      out_nxt.latency_min     = min_r;
      out_nxt.latency_max     = max_r;
      out_nxt.low_percentile  = res_zero_r ? '0 : prefix_a_r;
      out_nxt.high_percentile = res_zero_r ? '0 : prefix_b_r;
    end else begin
      out_nxt.query_result    = res_zero_r ? '0 : prefix_a_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= out_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  `LSPM_ASSERT(a_fill_bound, fill_r <= RING_N, "fill count past ring depth")
  `LSPM_ASSERT_IMPL(a_cnt_bound, state_r == ST_SCAN, (cnt_a_r <= n_r) && (i_r <= n_r), "scan count past window")
  `LSPM_ASSERT_NEXT(a_out_hold, out_valid_r && !out_pop, out_valid_r && $stable(out_r), "pending result changed")

endmodule

FILE: hw/rtl/latency_stats_percentile_monitor.sv
// top level of the latency statistics monitor with percentile selection
// depends on lspm_pkg, lspm_front, lspm_back
//
// Usage: items are pushed on in_push/in_data and refused while in_full is high.
// Function 0 records a request, 3 clears all statistics and the sample ring;
// neither gives a result. Function 1 (snapshot) and 2 (percentile query) each
// leave one result, shown on out_data while out_empty is low and taken by
// out_pop. Configuration writes (cfg_index 0 low, 1 high fraction) go through
// cfg_valid/cfg_ready and are always taken; issue them only while idle.
// Flow: a record or clear retires in the cycle it is taken from the four-entry
// command queue. A snapshot or query holds the back end through the MUL and
// INDEX states and a scan in which every answer bit takes one pass over the
// ring read port; it skips the scan for an empty window or a query fraction
// out of range. An item leaves the queue in the cycle after its transfer at
// the earliest; its result shows up after that hold, and a snapshot result
// also waits for the mean divider to finish.
// Reset clears statistics, ring pointers and fill count at once; ring contents
// are not cleared. When the receiver stalls, the result holds and the back end
// stops at the next result while records keep filling the queue.
module latency_stats_percentile_monitor
  import lspm_pkg::*;
#(
  parameter int RING_DEPTH = 1024,
  parameter int WINDOW     = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  lspm_in_t             in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output lspm_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAC_W-1:0]    cfg_data
);

  lspm_cfg_t cfg;
  lspm_cmd_t cmd;
  logic      cmd_valid;
  logic      cmd_ready;

  // front end with command queue
  lspm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // statistics and selection
  lspm_back #(
    .RING_DEPTH (RING_DEPTH),
    .WINDOW     (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg       (cfg),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
